FILE: hw/rtl/omni_wheel_odometry_pinv_core_assert.svh
// Assertion macros shared by the odometry core.
`ifndef OMNI_WHEEL_ODOMETRY_PINV_CORE_ASSERT_SVH
`define OMNI_WHEEL_ODOMETRY_PINV_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define OWO_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("owo assertion failed");
`define OWO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("owo assertion failed");
`else
`define OWO_ASSERT_IMPL(label, clk, rst, ante, cons)
`define OWO_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/owo_pkg.sv
`default_nettype none
package owo_pkg;
   localparam int WORD_W    = 32;
   localparam int REG_W     = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_DISTANCE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_RADIUS   = 1'd1;

   localparam logic [REG_W-1:0] WHEEL_DISTANCE_RESET = 16'd2099;
   localparam logic [REG_W-1:0] WHEEL_RADIUS_RESET   = 16'd640;

   typedef struct packed {
      logic signed [WORD_W-1:0] wheel_a;
      logic signed [WORD_W-1:0] wheel_b;
      logic signed [WORD_W-1:0] wheel_c;
      logic signed [WORD_W-1:0] wheel_d;
   } owo_req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] delta_x;
      logic signed [WORD_W-1:0] delta_y;
      logic signed [WORD_W-1:0] delta_heading;
      logic                     singular;
   } owo_rsp_type;
endpackage
`default_nettype wire

FILE: hw/rtl/owo_stream_if.sv
`default_nettype none
interface owo_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/omni_wheel_odometry_pinv_core.sv
// Channel   Direction  Beat payload                                  Handshake
// req_ch    in         wheel_a, wheel_b, wheel_c, wheel_d            valid/ready
// rsp_ch    out        delta_x, delta_y, delta_heading, singular     valid/ready
// csr_*     in         csr_index, csr_wdata                          csr_we only
//
// One beat enters per cycle while no stall at rsp_ch reaches the input. There are
// 38 register stages: the input register, three arithmetic stages, one overflow
// check, 32 restoring divider stages (one quotient bit each) and the saturating
// output register. A result is offered once its request beat has passed them all.
// Reset is synchronous and active high; it empties the pipeline and loads the
// register defaults. A stall at rsp_ch fills bubbles first and then holds
// every stage in place, so no beat is lost or repeated.
`default_nettype none
`include "omni_wheel_odometry_pinv_core_assert.svh"
module omni_wheel_odometry_pinv_core import owo_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   owo_stream_if.sink            req_ch,
   owo_stream_if.source          rsp_ch,
   input  wire                   csr_we,
   input  wire [CSR_IDX_W-1:0]   csr_index,
   input  wire [REG_W-1:0]       csr_wdata
);
   // Integer square root, evaluated at elaboration for the wheel constants.
   function automatic logic [63:0] isqrt(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = val;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > v) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   localparam int F   = FRAC_BITS;
   localparam int QW  = WORD_W;
   // Signed width of the y and heading numerators.
   localparam int PW  = F + 35;
   // Dividend magnitude, divisor and remainder widths.
   localparam int NW  = 2 * F + 50;
   localparam int DW  = 2 * F + 34;
   localparam int RW  = 2 * F + 67;
   localparam int DIV0 = 4;
   localparam int OUT  = DIV0 + QW + 1;
   localparam int NS   = OUT + 1;

   localparam logic [63:0] S3_U = isqrt(64'd3 << (2 * F - 2));
   localparam logic [63:0] S2_U = isqrt(64'd1 << (2 * F - 1));
   localparam logic [63:0] H_U  = 64'd1 << (F - 1);
   localparam logic [63:0] G_U  = H_U + S2_U;
   localparam logic [63:0] T_U  = 64'd2 * (S3_U * S3_U + S2_U * S2_U);

   localparam logic signed [PW-1:0] S3_P = PW'(S3_U);
   localparam logic signed [PW-1:0] S2_P = PW'(S2_U);
   localparam logic [DW-1:0]        G_D  = DW'(G_U);
   localparam logic [DW-1:0]        T_D  = DW'(T_U);

   // Configuration registers.
   logic [REG_W-1:0] dist_ff;
   logic [REG_W-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff   <= WHEEL_DISTANCE_RESET;
         radius_ff <= WHEEL_RADIUS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WHEEL_DISTANCE: dist_ff <= csr_wdata;
            CSR_WHEEL_RADIUS:   radius_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage enables: a stage loads when it is empty or its successor moves on.
   logic [NS-1:0] v_ff;
   logic [NS:0]   en;

   always_comb begin
      en[NS] = rsp_ch.ready;
      for (int k = NS - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) v_ff[k] <= (k == 0) ? req_ch.valid : v_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   assign req_ch.ready = en[0];
   assign rsp_ch.valid = v_ff[OUT];

   logic sing_ff [1:OUT-1];

   // Stage 0: input capture.
   logic signed [WORD_W-1:0] wa_ff, wb_ff, wc_ff, wd_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         wa_ff <= req_ch.payload.wheel_a;
         wb_ff <= req_ch.payload.wheel_b;
         wc_ff <= req_ch.payload.wheel_c;
         wd_ff <= req_ch.payload.wheel_d;
      end
   end

   // Stage 1: wheel pair sums and differences, divisor products.
   logic signed [WORD_W:0] a1_ff, b1_ff, dab1_ff, ddc1_ff;
   logic [2*REG_W-1:0]     lr1_ff;
   logic [DW-1:0]          gr1_ff, tr1_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         a1_ff   <= (WORD_W+1)'(wa_ff) + (WORD_W+1)'(wb_ff);
         b1_ff   <= (WORD_W+1)'(wc_ff) + (WORD_W+1)'(wd_ff);
         dab1_ff <= (WORD_W+1)'(wa_ff) - (WORD_W+1)'(wb_ff);
         ddc1_ff <= (WORD_W+1)'(wd_ff) - (WORD_W+1)'(wc_ff);
         lr1_ff  <= (2*REG_W)'(dist_ff) * (2*REG_W)'(radius_ff);
         gr1_ff  <= G_D * DW'(radius_ff);
         tr1_ff  <= T_D * DW'(radius_ff);
         sing_ff[1] <= (dist_ff == '0) || (radius_ff == '0);
      end
   end

   // Stage 2: products by the wheel direction constants.
   logic signed [WORD_W+1:0] bma2_ff;
   logic signed [PW-1:0]     py1_ff, py2_ff, pa2_ff, pb2_ff;
   logic [DW-1:0]            gr2_ff, tr2_ff, gl2_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         bma2_ff <= (WORD_W+2)'(b1_ff) - (WORD_W+2)'(a1_ff);
         py1_ff  <= PW'(dab1_ff) * S3_P;
         py2_ff  <= PW'(ddc1_ff) * S2_P;
         pa2_ff  <= PW'(a1_ff) * S2_P;
         pb2_ff  <= PW'(b1_ff) <<< (F - 1);
         gr2_ff  <= gr1_ff;
         tr2_ff  <= tr1_ff;
         gl2_ff  <= G_D * DW'(lr1_ff);
         sing_ff[2] <= sing_ff[1];
      end
   end

   // Stage 3: numerators to sign and scaled magnitude.
   logic signed [PW-1:0]   ny2, nt2;
   logic [WORD_W+1:0]      mx2;
   logic [PW-1:0]          my2, mt2;
   logic [NW-1:0]          n3_ff   [3];
   logic [DW-1:0]          d3_ff   [3];
   logic                   neg3_ff [3];

   always_comb begin
      ny2 = py1_ff + py2_ff;
      nt2 = pa2_ff + pb2_ff;
      mx2 = bma2_ff[WORD_W+1] ? (WORD_W+2)'(-bma2_ff) : (WORD_W+2)'(bma2_ff);
      my2 = ny2[PW-1] ? PW'(-ny2) : PW'(ny2);
      mt2 = nt2[PW-1] ? PW'(-nt2) : PW'(nt2);
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         n3_ff[0]   <= NW'(mx2) << (F + 7);
         n3_ff[1]   <= NW'(my2) << (F + 8);
         n3_ff[2]   <= NW'(mt2) << 15;
         d3_ff[0]   <= gr2_ff;
         d3_ff[1]   <= tr2_ff;
         d3_ff[2]   <= gl2_ff;
         neg3_ff[0] <= bma2_ff[WORD_W+1];
         neg3_ff[1] <= ny2[PW-1];
         neg3_ff[2] <= nt2[PW-1];
         sing_ff[3] <= sing_ff[2];
      end
   end

   // Divider lanes: x, y and heading. Slot 0 checks for a quotient that does
   // not fit in the result word; each later slot settles one quotient bit.
   logic [RW-1:0] rem_ff [3][QW+1];
   logic [DW-1:0] den_ff [3][QW+1];
   logic [QW-1:0] q_ff   [3][QW+1];
   logic          ovf_ff [3][QW+1];
   logic          neg_ff [3][QW+1];

   for (genvar l = 0; l < 3; l++) begin : g_lane
      always_ff @(posedge clock) begin
         if (en[DIV0]) begin
            rem_ff[l][0] <= RW'(n3_ff[l]);
            den_ff[l][0] <= d3_ff[l];
            q_ff[l][0]   <= '0;
            ovf_ff[l][0] <= RW'(n3_ff[l]) >= (RW'(d3_ff[l]) << QW);
            neg_ff[l][0] <= neg3_ff[l];
         end
      end

      for (genvar j = 1; j <= QW; j++) begin : g_bit
         localparam int K = QW - j;
         logic [RW-1:0] trial;
         logic          take;
         logic [RW-1:0] rem_in;
         logic [QW-1:0] q_in;

         assign trial  = RW'(den_ff[l][j-1]) << K;
         assign take   = rem_ff[l][j-1] >= trial;
         assign rem_in = take ? rem_ff[l][j-1] - trial : rem_ff[l][j-1];
         assign q_in   = q_ff[l][j-1] | (QW'(take) << K);

         always_ff @(posedge clock) begin
            if (en[DIV0+j]) begin
               rem_ff[l][j] <= rem_in;
               den_ff[l][j] <= den_ff[l][j-1];
               q_ff[l][j]   <= q_in;
               ovf_ff[l][j] <= ovf_ff[l][j-1];
               neg_ff[l][j] <= neg_ff[l][j-1];
            end
         end
      end
   end

   for (genvar k = DIV0; k < OUT; k++) begin : g_sing
      always_ff @(posedge clock) begin
         if (en[k]) sing_ff[k] <= sing_ff[k-1];
      end
   end

   // Sign restore with saturation to the signed word range.
   function automatic logic [WORD_W-1:0] sat_word(input logic [QW-1:0] q,
                                                  input logic ovf,
                                                  input logic neg);
      logic [WORD_W-1:0] res;
      if (neg) begin
         if (ovf || q > {1'b1, {(QW-1){1'b0}}}) res = {1'b1, {(WORD_W-1){1'b0}}};
         else res = WORD_W'(-q);
      end else begin
         if (ovf || q[QW-1]) res = {1'b0, {(WORD_W-1){1'b1}}};
         else res = WORD_W'(q);
      end
      return res;
   endfunction

   // Output register.
   logic [WORD_W-1:0] dx_ff, dy_ff, dh_ff;
   logic              sg_ff;

   always_ff @(posedge clock) begin
      if (en[OUT]) begin
         sg_ff <= sing_ff[OUT-1];
         if (sing_ff[OUT-1]) begin
            dx_ff <= '0;
            dy_ff <= '0;
            dh_ff <= '0;
         end else begin
            dx_ff <= sat_word(q_ff[0][QW], ovf_ff[0][QW], neg_ff[0][QW]);
            dy_ff <= sat_word(q_ff[1][QW], ovf_ff[1][QW], neg_ff[1][QW]);
            dh_ff <= sat_word(q_ff[2][QW], ovf_ff[2][QW], neg_ff[2][QW]);
         end
      end
   end

   assign rsp_ch.payload.delta_x       = dx_ff;
   assign rsp_ch.payload.delta_y       = dy_ff;
   assign rsp_ch.payload.delta_heading = dh_ff;
   assign rsp_ch.payload.singular      = sg_ff;

   // A singular result carries all-zero displacement fields.
   `OWO_ASSERT_IMPL(a_singular_zero, clock, reset, v_ff[OUT] && sg_ff, dx_ff == '0 && dy_ff == '0 && dh_ff == '0)
   // A held result stays valid, with delta_x and delta_heading unchanged in the output register.
   `OWO_ASSERT_NEXT(a_out_hold, clock, reset, v_ff[OUT] && !rsp_ch.ready, v_ff[OUT] && $stable(dx_ff) && $stable(dh_ff))
   // Without overflow the y-lane remainder entering the bit slots is below the scaled divisor.
   `OWO_ASSERT_IMPL(a_div_range, clock, reset, v_ff[DIV0] && !ovf_ff[1][0], rem_ff[1][0] < (RW'(den_ff[1][0]) << QW))
endmodule
`default_nettype wire
